// ===== hw/rtl/nas_pkg.sv =====
package nas_pkg;

   // alarm configuration
   localparam int ALARM_COUNT = 5;
   localparam int TIME_REGS   = 5;
   localparam int USED_ALARMS = (ALARM_COUNT < TIME_REGS) ? ALARM_COUNT : TIME_REGS;

   // field widths
   localparam int MODE_W     = 10;
   localparam int TIME_W     = 11;
   localparam int SCORE_W    = 12;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // minutes-of-day arithmetic
   localparam int DAY_MINUTES  = 24 * 60;
   localparam int HOUR_MINUTES = 60;
   // floor(v / 60) == (v * RECIP_60) >> RECIP_SHIFT for every v below one day
   localparam int RECIP_SHIFT  = 16;
   localparam int RECIP_60     = (1 << RECIP_SHIFT) / HOUR_MINUTES + 1;
   localparam int RECIP_W      = 11;
   localparam int PROD_W       = TIME_W + RECIP_W;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_MODES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_E = 3'd5;

   typedef logic [MODE_W-1:0]  modes_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [SCORE_W-1:0] score_val_type;
   typedef time_type [TIME_REGS-1:0] times_type;

   typedef struct packed {
      logic              init_request;
      logic [HOUR_W-1:0] now_hour;
      logic [MIN_W-1:0]  now_minute;
   } req_type;

   typedef struct packed {
      logic [HOUR_W-1:0] cur_alarm_hour;
      logic [MIN_W-1:0]  cur_alarm_minute;
      logic [HOUR_W-1:0] next_alarm_hour;
      logic [MIN_W-1:0]  next_alarm_minute;
      logic              next_alarm_on;
      logic              any_enabled;
   } rsp_type;

   // after the scoring stage
   typedef struct packed {
      logic          init;
      logic          any;
      score_val_type best;
   } score_type;

   // after the modulo / hour split stage
   typedef struct packed {
      logic              init;
      logic              any;
      time_type          value;
      logic [HOUR_W-1:0] hour;
   } split_type;

   // hour * 60 + minute, as shift-add
   function automatic time_type to_minutes(input logic [HOUR_W-1:0] hour,
                                           input logic [MIN_W-1:0]  minute);
      time_type h;
      h = TIME_W'(hour);
      return (h << 6) - (h << 2) + TIME_W'(minute);
   endfunction

endpackage

// ===== hw/rtl/nas_csr.sv =====
module nas_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [nas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nas_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output nas_pkg::modes_type                  modes,
   output nas_pkg::times_type                  times
);

   nas_pkg::modes_type modes_ff;
   nas_pkg::times_type times_ff;
   logic [nas_pkg::CSR_IDX_W-1:0] slot;

   // time register slot; only meaningful inside the time range
   assign slot = csr_index - nas_pkg::CSR_TIME_A;

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= '0;
         times_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == nas_pkg::CSR_MODES) begin
            modes_ff <= nas_pkg::MODE_W'(csr_wdata);
         end else if (csr_index >= nas_pkg::CSR_TIME_A &&
                      csr_index <= nas_pkg::CSR_TIME_E) begin
            times_ff[slot] <= nas_pkg::TIME_W'(csr_wdata);
         end
      end
   end

   assign modes = modes_ff;
   assign times = times_ff;

endmodule

// ===== hw/rtl/nas_score.sv =====
module nas_score (
   input  logic                init,
   input  nas_pkg::time_type   now,
   input  nas_pkg::modes_type  modes,
   input  nas_pkg::times_type  times,
   output nas_pkg::score_type  result
);

   always_comb begin
      nas_pkg::score_val_type score;
      nas_pkg::score_val_type best;
      logic                   any;
      best = '0;
      any  = 1'b0;
      // earliest upcoming alarm; alarms not later than now wrap to tomorrow
      for (int i = 0; i < nas_pkg::USED_ALARMS; i++) begin
         if (now < times[i]) begin
            score = nas_pkg::SCORE_W'(times[i]);
         end else begin
            score = nas_pkg::SCORE_W'(times[i]) + nas_pkg::SCORE_W'(nas_pkg::DAY_MINUTES);
         end
         if (modes[2*i]) begin
            if (!any || score < best) begin
               best = score;
            end
            any = 1'b1;
         end
      end
      result.init = init;
      result.any  = any;
      result.best = best;
   end

endmodule

// ===== hw/rtl/nas_split.sv =====
module nas_split (
   input  nas_pkg::score_type score,
   output nas_pkg::split_type result
);

   nas_pkg::time_type                  value;
   logic [nas_pkg::PROD_W-1:0]         prod;

   // best score is below three days, so two conditional subtracts reduce it
   always_comb begin
      if (score.best >= nas_pkg::SCORE_W'(2 * nas_pkg::DAY_MINUTES)) begin
         value = nas_pkg::TIME_W'(score.best - nas_pkg::SCORE_W'(2 * nas_pkg::DAY_MINUTES));
      end else if (score.best >= nas_pkg::SCORE_W'(nas_pkg::DAY_MINUTES)) begin
         value = nas_pkg::TIME_W'(score.best - nas_pkg::SCORE_W'(nas_pkg::DAY_MINUTES));
      end else begin
         value = nas_pkg::TIME_W'(score.best);
      end
   end

   // hour by reciprocal multiply
   assign prod = nas_pkg::PROD_W'(value) * nas_pkg::PROD_W'(nas_pkg::RECIP_60);

   assign result.init  = score.init;
   assign result.any   = score.any;
   assign result.value = value;
   assign result.hour  = prod[nas_pkg::RECIP_SHIFT +: nas_pkg::HOUR_W];

endmodule

// ===== hw/rtl/nas_track.sv =====
module nas_track (
   input  logic               clock,
   input  logic               reset,
   input  logic               update,
   input  nas_pkg::split_type split,
   input  nas_pkg::modes_type modes,
   input  nas_pkg::times_type times,
   output nas_pkg::rsp_type   rsp
);

   logic [nas_pkg::HOUR_W-1:0] cur_hour_ff,   cur_hour_in;
   logic [nas_pkg::MIN_W-1:0]  cur_minute_ff, cur_minute_in;
   logic [nas_pkg::HOUR_W-1:0] next_hour_ff,  next_hour_in;
   logic [nas_pkg::MIN_W-1:0]  next_minute_ff, next_minute_in;
   nas_pkg::time_type          next_time_ff,  next_time_in;
   logic                       next_on_ff,    next_on_in;
   logic                       any_ff,        any_in;
   nas_pkg::time_type          hour_part;
   logic [nas_pkg::MIN_W-1:0]  minute;

   // minute = value - hour * 60
   assign hour_part = (nas_pkg::TIME_W'(split.hour) << 6) - (nas_pkg::TIME_W'(split.hour) << 2);
   assign minute    = nas_pkg::MIN_W'(split.value - hour_part);

   always_comb begin
      cur_hour_in    = cur_hour_ff;
      cur_minute_in  = cur_minute_ff;
      next_hour_in   = next_hour_ff;
      next_minute_in = next_minute_ff;
      next_time_in   = next_time_ff;
      if (split.any) begin
         if (split.init) begin
            cur_hour_in   = split.hour;
            cur_minute_in = minute;
         end else begin
            cur_hour_in   = next_hour_ff;
            cur_minute_in = next_minute_ff;
         end
         next_hour_in   = split.hour;
         next_minute_in = minute;
         next_time_in   = split.value;
      end
      // highest matching alarm decides the flag; no match keeps it
      next_on_in = next_on_ff;
      for (int i = 0; i < nas_pkg::USED_ALARMS; i++) begin
         if (times[i] == next_time_in) begin
            next_on_in = modes[2*i];
         end
      end
      any_in = split.any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_hour_ff    <= '0;
         cur_minute_ff  <= '0;
         next_hour_ff   <= '0;
         next_minute_ff <= '0;
         next_time_ff   <= '0;
         next_on_ff     <= 1'b0;
         any_ff         <= 1'b0;
      end else if (update) begin
         cur_hour_ff    <= cur_hour_in;
         cur_minute_ff  <= cur_minute_in;
         next_hour_ff   <= next_hour_in;
         next_minute_ff <= next_minute_in;
         next_time_ff   <= next_time_in;
         next_on_ff     <= next_on_in;
         any_ff         <= any_in;
      end
   end

   assign rsp.cur_alarm_hour    = cur_hour_ff;
   assign rsp.cur_alarm_minute  = cur_minute_ff;
   assign rsp.next_alarm_hour   = next_hour_ff;
   assign rsp.next_alarm_minute = next_minute_ff;
   assign rsp.next_alarm_on     = next_on_ff;
   assign rsp.any_enabled       = any_ff;

endmodule

// ===== hw/rtl/next_alarm_selector.sv =====
// Channel  Direction  Handshake              Word
// req      in         req_valid/req_ready    nas_pkg::req_type (init, hour, minute)
// rsp      out        rsp_valid/rsp_ready    nas_pkg::rsp_type (cur, next, on, any)
// csr      in         csr_write_enable       csr_index selects, csr_wdata 11 bits
//
// Two register stages: input (minutes of day) and alarm state. Scoring, the
// modulo and hour split and the flag match are one combinational pass between
// them. The alarm state registers are the response word.
// One word per cycle unless rsp is held; rsp valid comes from s1_valid_ff.
// Synchronous reset clears all alarm state and configuration to zero.
// A response waiting on rsp_ready freezes both stages; req_ready drops with it.
module next_alarm_selector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nas_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nas_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [nas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nas_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   nas_pkg::modes_type modes;
   nas_pkg::times_type times;

   // pipeline control
   logic advance;
   logic s1_valid_ff, rsp_valid_ff;

   // stage payloads
   logic                 s1_init_ff;
   nas_pkg::time_type    s1_now_ff;
   nas_pkg::score_type   score_comb;
   nas_pkg::split_type   split_comb;

   // whole pipe moves unless a response is held
   assign advance   = !(rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // input register, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_init_ff <= req_data.init_request;
         s1_now_ff  <= nas_pkg::to_minutes(req_data.now_hour, req_data.now_minute);
      end
   end

   nas_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .modes            (modes),
      .times            (times)
   );

   // score each enabled alarm, keep the earliest
   nas_score u_score (
      .init   (s1_init_ff),
      .now    (s1_now_ff),
      .modes  (modes),
      .times  (times),
      .result (score_comb)
   );

   // reduce to time of day, split off the hour
   nas_split u_split (
      .score  (score_comb),
      .result (split_comb)
   );

   // current/next alarm state and on flag
   nas_track u_track (
      .clock  (clock),
      .reset  (reset),
      .update (advance && s1_valid_ff),
      .split  (split_comb),
      .modes  (modes),
      .times  (times),
      .rsp    (rsp_data)
   );

`ifndef ASSERT_OFF
   // next alarm is always a valid time of day
   a_next_in_day: assert property (@(posedge clock) disable iff (reset)
      nas_pkg::to_minutes(rsp_data.next_alarm_hour, rsp_data.next_alarm_minute)
         < nas_pkg::TIME_W'(nas_pkg::DAY_MINUTES))
      else $error("next alarm outside one day");

   // a response only appears out of the input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("response without a word in the input stage");

   // held response freezes the input stage and the alarm state
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(s1_valid_ff) && $stable(rsp_data))
      else $error("pipeline moved during a stall");
`endif

endmodule

// ===== tb/next_alarm_checker.sv =====
module next_alarm_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  nas_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  nas_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [nas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nas_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              expected_left
);

   localparam int PRINT_CAP = 30;

   // shadow of the alarm set-up and of the alarm state registers
   nas_pkg::modes_type            alarm_modes;
   nas_pkg::time_type             alarm_times [nas_pkg::TIME_REGS];
   logic [nas_pkg::HOUR_W-1:0]    cur_hour;
   logic [nas_pkg::MIN_W-1:0]     cur_minute;
   logic [nas_pkg::HOUR_W-1:0]    next_hour;
   logic [nas_pkg::MIN_W-1:0]     next_minute;
   logic                          next_on;
   nas_pkg::rsp_type              expected_alarms [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   // earliest enabled alarm strictly after now, wrapping into tomorrow
   task automatic predict_next_alarm(input nas_pkg::req_type word);
      int now_min;
      int score;
      int best;
      int value;
      int next_min;
      bit any;
      nas_pkg::rsp_type want;
      now_min = int'(word.now_hour) * nas_pkg::HOUR_MINUTES + int'(word.now_minute);
      any     = 1'b0;
      best    = 0;
      for (int slot = 0; slot < nas_pkg::USED_ALARMS; slot++) begin
         if (alarm_modes[2*slot]) begin
            score = int'(alarm_times[slot]);
            if (now_min >= score)
               score += nas_pkg::DAY_MINUTES;
            if (!any || score < best)
               best = score;
            any = 1'b1;
         end
      end
      if (any) begin
         value = best % nas_pkg::DAY_MINUTES;
         if (word.init_request) begin
            cur_hour   = nas_pkg::HOUR_W'(value / nas_pkg::HOUR_MINUTES);
            cur_minute = nas_pkg::MIN_W'(value % nas_pkg::HOUR_MINUTES);
         end else begin
            cur_hour   = next_hour;
            cur_minute = next_minute;
         end
         next_hour   = nas_pkg::HOUR_W'(value / nas_pkg::HOUR_MINUTES);
         next_minute = nas_pkg::MIN_W'(value % nas_pkg::HOUR_MINUTES);
      end
      // flag follows the highest-numbered alarm sitting on the next time
      next_min = int'(next_hour) * nas_pkg::HOUR_MINUTES + int'(next_minute);
      for (int slot = 0; slot < nas_pkg::USED_ALARMS; slot++) begin
         if (int'(alarm_times[slot]) == next_min)
            next_on = alarm_modes[2*slot];
      end
      want.cur_alarm_hour    = cur_hour;
      want.cur_alarm_minute  = cur_minute;
      want.next_alarm_hour   = next_hour;
      want.next_alarm_minute = next_minute;
      want.next_alarm_on     = next_on;
      want.any_enabled       = any;
      expected_alarms.push_back(want);
   endtask

   task automatic check_word(input nas_pkg::rsp_type got);
      nas_pkg::rsp_type want;
      if (expected_alarms.size() == 0) begin
         report_mismatch("word with nothing pending", int'(got), 0);
      end else begin
         want = expected_alarms.pop_front();
         if (got.cur_alarm_hour !== want.cur_alarm_hour)
            report_mismatch("cur_alarm_hour", got.cur_alarm_hour, want.cur_alarm_hour);
         if (got.cur_alarm_minute !== want.cur_alarm_minute)
            report_mismatch("cur_alarm_minute", got.cur_alarm_minute, want.cur_alarm_minute);
         if (got.next_alarm_hour !== want.next_alarm_hour)
            report_mismatch("next_alarm_hour", got.next_alarm_hour, want.next_alarm_hour);
         if (got.next_alarm_minute !== want.next_alarm_minute)
            report_mismatch("next_alarm_minute", got.next_alarm_minute,
                            want.next_alarm_minute);
         if (got.next_alarm_on !== want.next_alarm_on)
            report_mismatch("next_alarm_on", got.next_alarm_on, want.next_alarm_on);
         if (got.any_enabled !== want.any_enabled)
            report_mismatch("any_enabled", got.any_enabled, want.any_enabled);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         alarm_modes    = '0;
         for (int slot = 0; slot < nas_pkg::TIME_REGS; slot++)
            alarm_times[slot] = '0;
         cur_hour       = '0;
         cur_minute     = '0;
         next_hour      = '0;
         next_minute    = '0;
         next_on        = 1'b0;
         mismatch_count = 0;
         expected_alarms.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == nas_pkg::CSR_MODES)
               alarm_modes = csr_wdata[nas_pkg::MODE_W-1:0];
            else if (csr_index >= nas_pkg::CSR_TIME_A && csr_index <= nas_pkg::CSR_TIME_E)
               alarm_times[csr_index - nas_pkg::CSR_TIME_A] = csr_wdata[nas_pkg::TIME_W-1:0];
         end
         if (req_valid && req_ready)
            predict_next_alarm(req_data);
         if (rsp_valid && rsp_ready)
            check_word(rsp_data);
      end
      expected_left = expected_alarms.size();
   end

endmodule

// ===== tb/next_alarm_selector_tb.sv =====
module next_alarm_selector_tb;

   localparam int WORDS_PER_PHASE = 160;   // random words per alarm set-up
   localparam int RANDOM_PHASES   = 12;
   localparam int PRESSURE_PHASE  = 2;     // phase that opens with the long hold-off
   localparam int PRESSURE_WORDS  = 40;    // offered back to back during the hold-off
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 8;     // pipeline is two deep
   localparam int IDLE_LIMIT      = 4000;  // cycles with no handshake of any kind

   // spare register indexes past the last alarm time, must be ignored
   localparam logic [nas_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO =
      nas_pkg::CSR_IDX_W'(nas_pkg::CSR_TIME_E + 1);
   localparam logic [nas_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI =
      nas_pkg::CSR_IDX_W'(nas_pkg::CSR_TIME_E + 2);

   typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} stall_style_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   nas_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   nas_pkg::rsp_type                rsp_data;
   logic                            csr_write_enable;
   logic [nas_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [nas_pkg::CSR_DATA_W-1:0]  csr_wdata;
   int                              mismatch_count;
   int                              expected_left;

   logic                            req_took;      // word accepted at the last rising edge
   logic                            hold_pending;  // main asks the receiver for a hold-off
   int                              idle_cycles;
   int                              words_sent;
   int                              init_words;
   int                              setups;
   int                              results_seen;
   nas_pkg::times_type              cur_times;     // alarm times now loaded, for aiming now

   stall_style_type                 stall_style;
   int                              stall_left;
   int                              stall_tick;

   next_alarm_selector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   next_alarm_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .expected_left    (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Handshakes are sampled at the rising edge like any flop; the driving
   // processes only look at req_took at the falling edge that follows.
   // The watchdog restarts on any word moved or register written.
   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      if (rsp_valid && rsp_ready)
         results_seen <= results_seen + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results pending",
                  idle_cycles, expected_left);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: stretches of different stall styles, always-ready among them,
   // plus one long hold-off on request so the pipeline backs up into req_ready.
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      stall_tick = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (stall_left == 0) begin
               stall_style = stall_style_type'($urandom_range(0, 3));
               stall_left  = $urandom_range(10, 80);
            end
            stall_left--;
            stall_tick++;
            case (stall_style)
               READY_ALWAYS: begin
                  rsp_ready <= 1'b1;
               end
               READY_COIN: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               READY_MOSTLY: begin
                  rsp_ready <= ($urandom_range(0, 7) != 0);
               end
               default: begin
                  rsp_ready <= (stall_tick % 5 < 3);
               end
            endcase
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance,
   // with valid still high so a following word goes out without a bubble.
   task automatic send_word(input nas_pkg::req_type word);
      req_valid <= 1'b1;
      req_data  <= word;
      words_sent++;
      if (word.init_request)
         init_words++;
      do @(negedge clock); while (!req_took);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Quiet the sender and let every expected word come back before any
   // register is touched.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Back-to-back register writes; the spare indexes get junk that must not land.
   task automatic load_alarms(input logic [nas_pkg::CSR_DATA_W-1:0] mode_word,
                              input nas_pkg::times_type times, input bit spare_writes);
      csr_write_enable <= 1'b1;
      csr_index        <= nas_pkg::CSR_MODES;
      csr_wdata        <= mode_word;
      @(negedge clock);
      for (int slot = 0; slot < nas_pkg::TIME_REGS; slot++) begin
         csr_index <= nas_pkg::CSR_TIME_A + nas_pkg::CSR_IDX_W'(slot);
         csr_wdata <= times[slot];
         @(negedge clock);
      end
      if (spare_writes) begin
         csr_index <= CSR_SPARE_LO;
         csr_wdata <= nas_pkg::CSR_DATA_W'($urandom);
         @(negedge clock);
         csr_index <= CSR_SPARE_HI;
         csr_wdata <= nas_pkg::CSR_DATA_W'($urandom);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      cur_times = times;
      setups++;
   endtask

   function automatic nas_pkg::req_type clock_word(input bit init, input int hour,
                                                   input int minute);
      nas_pkg::req_type word;
      word.init_request = init;
      word.now_hour     = nas_pkg::HOUR_W'(hour);
      word.now_minute   = nas_pkg::MIN_W'(minute);
      return word;
   endfunction

   // Mostly legal times of day; a share lands on or next to a loaded alarm
   // (the strictly-later boundary), a share is raw out-of-range bits.
   function automatic nas_pkg::req_type random_word();
      nas_pkg::req_type word;
      int mins;
      int slot;
      word.init_request = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
         0: begin
            word.now_hour   = nas_pkg::HOUR_W'($urandom);
            word.now_minute = nas_pkg::MIN_W'($urandom);
         end
         1, 2, 3: begin
            slot = $urandom_range(0, nas_pkg::TIME_REGS - 1);
            mins = int'(cur_times[slot]) + int'($urandom_range(0, 2)) - 1;
            mins = (mins + nas_pkg::DAY_MINUTES) % nas_pkg::DAY_MINUTES;
            word.now_hour   = nas_pkg::HOUR_W'(mins / nas_pkg::HOUR_MINUTES);
            word.now_minute = nas_pkg::MIN_W'(mins % nas_pkg::HOUR_MINUTES);
         end
         default: begin
            word.now_hour   = nas_pkg::HOUR_W'($urandom_range(0, 23));
            word.now_minute = nas_pkg::MIN_W'($urandom_range(0, 59));
         end
      endcase
      return word;
   endfunction

   initial begin
      logic [nas_pkg::CSR_DATA_W-1:0] mode_word;
      nas_pkg::times_type             phase_times;
      int                             sent;
      int                             burst;
      bit                             steady;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      hold_pending     = 1'b0;
      req_took         = 1'b0;
      idle_cycles      = 0;
      words_sent       = 0;
      init_words       = 0;
      setups           = 0;
      results_seen     = 0;
      cur_times        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // all alarms on (spare mode bits too), times at both ends of the day,
      // one past the end and the largest the register holds
      phase_times[0] = 0;
      phase_times[1] = 1439;
      phase_times[2] = 720;
      phase_times[3] = 2047;
      phase_times[4] = 1440;
      load_alarms(11'h7FF, phase_times, 1'b0);
      send_word(clock_word(1, 0, 0));
      send_word(clock_word(0, 23, 59));
      send_word(clock_word(0, 12, 0));    // now equals an alarm: it moves to tomorrow
      send_word(clock_word(0, 11, 59));
      send_word(clock_word(0, 31, 63));   // hour and minute past their legal range
      send_word(clock_word(1, 23, 58));
      send_word(clock_word(0, 0, 0));
      send_word(clock_word(0, 16, 32));
      settle();

      // only the unused mode bits set: nothing enabled, times hold,
      // flag still follows the alarms sitting on the next time
      phase_times = '{default: 11'd600};
      load_alarms(11'h2AA, phase_times, 1'b0);
      send_word(clock_word(0, 10, 0));
      send_word(clock_word(1, 5, 5));
      send_word(clock_word(0, 31, 63));
      settle();

      // two alarms on the same time, the later one disabled: it wins the flag
      phase_times[0] = 600;
      phase_times[1] = 600;
      phase_times[2] = 1439;
      phase_times[3] = 0;
      phase_times[4] = 2047;
      load_alarms(11'h001, phase_times, 1'b1);
      send_word(clock_word(1, 9, 59));
      send_word(clock_word(0, 10, 0));
      send_word(clock_word(0, 10, 1));
      send_word(clock_word(0, 23, 59));
      settle();

      // only the out-of-range alarm enabled: reduced modulo a day, never flagged
      phase_times    = '0;
      phase_times[4] = 2047;
      load_alarms(11'h100, phase_times, 1'b0);
      send_word(clock_word(1, 0, 0));
      send_word(clock_word(0, 12, 0));
      send_word(clock_word(0, 31, 63));
      settle();

      // --- random ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: mode_word = {1'($urandom), 10'h3FF};
            1: mode_word = nas_pkg::CSR_DATA_W'($urandom) & 11'h6AA;   // none enabled
            2: mode_word = nas_pkg::CSR_DATA_W'(1 << (2 * $urandom_range(0, 4)));
            default: mode_word = nas_pkg::CSR_DATA_W'($urandom);
         endcase
         for (int slot = 0; slot < nas_pkg::TIME_REGS; slot++) begin
            case ($urandom_range(0, 7))
               0: phase_times[slot] = 0;
               1: phase_times[slot] = 1439;
               2: phase_times[slot] = nas_pkg::TIME_W'($urandom_range(1440, 2047));
               3: phase_times[slot] = (slot > 0) ? phase_times[slot-1]
                                                 : nas_pkg::TIME_W'($urandom_range(0, 1439));
               default: phase_times[slot] = nas_pkg::TIME_W'($urandom_range(0, 1439));
            endcase
         end
         load_alarms(mode_word, phase_times, ($urandom_range(0, 2) == 0));

         sent = 0;
         if (phase == PRESSURE_PHASE) begin
            // receiver stops; keep offering until req_ready drops and stays down
            hold_pending = 1'b1;
            for (int k = 0; k < PRESSURE_WORDS; k++)
               send_word(random_word());
            sent = PRESSURE_WORDS;
         end
         steady = ($urandom_range(0, 3) == 0);
         while (sent < WORDS_PER_PHASE) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < WORDS_PER_PHASE; k++) begin
               send_word(random_word());
               sent++;
            end
            if (!steady && $urandom_range(0, 3) != 0)
               pause_sender($urandom_range(1, 6));
         end
         settle();
      end

      $display("covered %0d words (%0d with init) under %0d alarm set-ups,",
               words_sent, init_words, setups);
      $display("  %0d results compared, including a %0d-cycle receiver hold-off",
               results_seen, HOLD_CYCLES);
      if (mismatch_count == 0 && expected_left == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
